// ===== src/rfd_pkg.sv =====
// Types, constants and the CRC step shared by the frame deframer.
package rfd_pkg;

   // Largest payload length that is accepted as legal.
   localparam logic [7:0]  MaxPayload   = 8'd64;

   localparam logic [15:0] CrcInit      = 16'hFFFF;
   localparam logic [15:0] CrcPoly      = 16'hA001;

   localparam logic [8:0]  MinFrame     = 9'd13;
   localparam logic [8:0]  CounterMax   = 9'd511;

   // Byte positions within a frame.
   localparam logic [8:0]  PosSyncFirst  = 9'd0;
   localparam logic [8:0]  PosSyncSecond = 9'd1;
   localparam logic [8:0]  PosVersion    = 9'd2;
   localparam logic [8:0]  PosCrcStart   = 9'd4;
   localparam logic [8:0]  PosFlowLow    = 9'd8;
   localparam logic [8:0]  PosFlowHigh   = 9'd9;
   localparam logic [8:0]  PosLength     = 9'd10;
   localparam logic [8:0]  PosPayload    = 9'd11;

   localparam int          NumHdrBytes   = 6;

   // Configuration register indexes.
   localparam logic [0:0]  CsrSyncFirst  = 1'b0;
   localparam logic [0:0]  CsrSyncSecond = 1'b1;

   typedef enum logic [0:0] {
      KIND_PAYLOAD = 1'b0,
      KIND_REPORT  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_HEADER   = 3'd2,
      ST_LENGTH   = 3'd3,
      ST_MISMATCH = 3'd4,
      ST_CRC      = 3'd5
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      status_type  status;
      logic [7:0]  version;
      logic [7:0]  msg_kind;
      logic [7:0]  src_role;
      logic [7:0]  src_group;
      logic [7:0]  dst_role;
      logic [7:0]  dst_group;
      logic [15:0] flow;
      logic [7:0]  count;
   } rsp_item_type;

   // One byte of CRC-16/MODBUS, reflected, unrolled over the eight bits.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== src/radio_frame_deframer_crc16.sv =====
// A result is registered in the result register, or first in the skid register.
// Throughput: one byte per cycle while req_stall is low; the CRC step is unrolled.
// A two-entry output (result register plus skid register) keeps bytes flowing
// while the consumer stalls, until req_stall rises once both entries are full.
// Reset (synchronous, active high) clears the frame state, the sync bytes and
// both output entries; the next byte is taken as frame byte 0.
module radio_frame_deframer_crc16 import rfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_frame,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_item_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_payload_index,
   output logic [2:0]  rsp_frame_status,
   output logic [7:0]  rsp_version_field,
   output logic [7:0]  rsp_message_kind,
   output logic [7:0]  rsp_source_role_field,
   output logic [7:0]  rsp_source_group_field,
   output logic [7:0]  rsp_dest_role_field,
   output logic [7:0]  rsp_dest_group_field,
   output logic [15:0] rsp_flow_ident,
   output logic [7:0]  rsp_payload_count,

   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   // Configuration.
   logic [7:0]  sync_first_ff;
   logic [7:0]  sync_second_ff;

   // Frame state.
   logic [8:0]  byte_counter_ff, byte_counter_in;
   logic [15:0] crc_ff, crc_in;
   logic        match_ff, match_in;
   logic [7:0]  hdr_ff [NumHdrBytes];
   logic [7:0]  hdr_in [NumHdrBytes];
   logic [7:0]  count_ff, count_in;
   logic [15:0] flow_ff, flow_in;
   logic [15:0] check_ff, check_in;

   // Output entries.
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   logic         skid_valid_ff;
   rsp_item_type skid_item_ff;

   logic         req_xfer;
   logic         forward;
   logic         has_result;
   logic [8:0]   payload_end;
   status_type   status;
   rsp_item_type result;

   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= 8'h00;
         sync_second_ff <= 8'h00;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrSyncFirst:  sync_first_ff  <= csr_write_data;
            CsrSyncSecond: sync_second_ff <= csr_write_data;
         endcase
      end
   end

   // Next frame state and the result for the byte on the input.
   always_comb begin
      logic [8:0] p;
      p = byte_counter_ff;

      if (p == PosSyncFirst) begin
         match_in = (req_data_byte == sync_first_ff);
      end else if (p == PosSyncSecond) begin
         match_in = match_ff && (req_data_byte == sync_second_ff);
      end else begin
         match_in = match_ff;
      end

      for (int i = 0; i < NumHdrBytes; i++) begin
         hdr_in[i] = (p == PosVersion + 9'(i)) ? req_data_byte : hdr_ff[i];
      end

      flow_in = flow_ff;
      if (p == PosFlowLow) begin
         flow_in[7:0] = req_data_byte;
      end
      if (p == PosFlowHigh) begin
         flow_in[15:8] = req_data_byte;
      end
      count_in = (p == PosLength) ? req_data_byte : count_ff;

      // The CRC runs two bytes behind, so the trailing check bytes never enter it.
      crc_in   = (p >= PosCrcStart) ? crc_byte(crc_ff, check_ff[7:0]) : crc_ff;
      check_in = {req_data_byte, check_ff[15:8]};

      byte_counter_in = (p < CounterMax) ? p + 9'd1 : p;

      payload_end = PosLength + {1'b0, count_in};
      forward = !req_end_of_frame && (p >= PosPayload) && (p <= payload_end) &&
                match_in && (count_in <= MaxPayload);
      has_result = req_end_of_frame || forward;

      if (byte_counter_in < MinFrame) begin
         status = ST_SHORT;
      end else if (!match_in) begin
         status = ST_HEADER;
      end else if (count_in > MaxPayload) begin
         status = ST_LENGTH;
      end else if (byte_counter_in != MinFrame + {1'b0, count_in}) begin
         status = ST_MISMATCH;
      end else if (crc_in != check_in) begin
         status = ST_CRC;
      end else begin
         status = ST_OK;
      end

      result = '0;
      if (req_end_of_frame) begin
         result.kind      = KIND_REPORT;
         result.status    = status;
         result.version   = hdr_in[0];
         result.msg_kind  = hdr_in[1];
         result.src_role  = hdr_in[2];
         result.src_group = hdr_in[3];
         result.dst_role  = hdr_in[4];
         result.dst_group = hdr_in[5];
         result.flow      = flow_in;
         result.count     = count_in;
      end else begin
         result.kind          = KIND_PAYLOAD;
         result.payload_byte  = req_data_byte;
         result.payload_index = 8'(p - PosPayload);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_counter_ff <= 9'd0;
         crc_ff          <= CrcInit;
         match_ff        <= 1'b1;
         count_ff        <= 8'h00;
         flow_ff         <= 16'h0000;
         check_ff        <= 16'h0000;
         for (int i = 0; i < NumHdrBytes; i++) begin
            hdr_ff[i] <= 8'h00;
         end
      end else if (req_xfer) begin
         if (req_end_of_frame) begin
            byte_counter_ff <= 9'd0;
            crc_ff          <= CrcInit;
            match_ff        <= 1'b1;
            count_ff        <= 8'h00;
            flow_ff         <= 16'h0000;
            check_ff        <= 16'h0000;
            for (int i = 0; i < NumHdrBytes; i++) begin
               hdr_ff[i] <= 8'h00;
            end
         end else begin
            byte_counter_ff <= byte_counter_in;
            crc_ff          <= crc_in;
            match_ff        <= match_in;
            count_ff        <= count_in;
            flow_ff         <= flow_in;
            check_ff        <= check_in;
            for (int i = 0; i < NumHdrBytes; i++) begin
               hdr_ff[i] <= hdr_in[i];
            end
         end
      end
   end

   // Output register with a skid entry behind it. A new result can only arrive
   // while the skid entry is empty, since req_stall follows it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_xfer && has_result;
         end
      end else if (req_xfer && has_result) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || !rsp_stall) begin
         out_item_ff <= skid_valid_ff ? skid_item_ff : result;
      end else if (req_xfer && has_result) begin
         skid_item_ff <= result;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_item_kind          = out_item_ff.kind;
   assign rsp_payload_byte       = out_item_ff.payload_byte;
   assign rsp_payload_index      = out_item_ff.payload_index;
   assign rsp_frame_status       = out_item_ff.status;
   assign rsp_version_field      = out_item_ff.version;
   assign rsp_message_kind       = out_item_ff.msg_kind;
   assign rsp_source_role_field  = out_item_ff.src_role;
   assign rsp_source_group_field = out_item_ff.src_group;
   assign rsp_dest_role_field    = out_item_ff.dst_role;
   assign rsp_dest_group_field   = out_item_ff.dst_group;
   assign rsp_flow_ident         = out_item_ff.flow;
   assign rsp_payload_count      = out_item_ff.count;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_end_of_frame) |=> (byte_counter_ff == 9'd0 && crc_ff == CrcInit))
      else $error("frame state not cleared after the last byte");

   a_crc_idle_early: assert property (@(posedge clock) disable iff (reset)
      (byte_counter_ff <= PosCrcStart) |-> (crc_ff == CrcInit))
      else $error("CRC changed before the first covered byte was folded in");

   a_payload_no_status: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.kind == KIND_PAYLOAD) |->
         (out_item_ff.status == ST_OK && out_item_ff.count == 8'h00))
      else $error("payload transfer carries report fields");

endmodule
